FILE: rtl/sbec_pkg.sv
// Package for the segment/box side crossing counter.
// Holds widths, the data types passed between pipeline stages and the side count.
// No dependencies.
package sbec_pkg;

  // Coordinate and derived widths.
  localparam int CoordWidth = 16;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int NormWidth  = CoordWidth + 2;
  localparam int ProdWidth  = 2 * NormWidth;
  localparam int NumSides   = 4;
  localparam int CountWidth = 3;

  // Maximum count that can be produced (one per side).
  localparam logic [CountWidth-1:0] MaxCount = CountWidth'(NumSides);

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [NormWidth-1:0]  norm_t;
  typedef logic signed [ProdWidth-1:0]  prod_t;

  // Coordinates relative to the segment start.
  typedef struct packed {
    diff_t dx;
    diff_t dy;
    diff_t ox0;
    diff_t ox1;
    diff_t oy0;
    diff_t oy1;
  } diff_set_t;

  // One side test with the tested axis delta made positive.
  typedef struct packed {
    logic  live;
    norm_t n;
    norm_t d;
    norm_t dv;
    norm_t lo;
    norm_t hi;
  } side_t;

  typedef side_t [NumSides-1:0] side_arr_t;

  // Products of one side test: lo*d <= n*dv <= hi*d.
  typedef struct packed {
    logic  live;
    prod_t lo_p;
    prod_t mid_p;
    prod_t hi_p;
  } prod_side_t;

  typedef prod_side_t [NumSides-1:0] prod_arr_t;

endpackage

FILE: rtl/sbec_diff.sv
// First pipeline stage: coordinates relative to the segment start.
// Depends on sbec_pkg.
module sbec_diff (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  sbec_pkg::coord_t    box_min_x_i,
  input  sbec_pkg::coord_t    box_min_y_i,
  input  sbec_pkg::coord_t    box_max_x_i,
  input  sbec_pkg::coord_t    box_max_y_i,
  input  sbec_pkg::coord_t    seg_start_x_i,
  input  sbec_pkg::coord_t    seg_start_y_i,
  input  sbec_pkg::coord_t    seg_end_x_i,
  input  sbec_pkg::coord_t    seg_end_y_i,
  output logic                valid_o,
  input  logic                ready_i,
  output sbec_pkg::diff_set_t diff_o
);
  import sbec_pkg::*;

  logic      valid_q;
  diff_set_t diff_d, diff_q;

  // Sign-extend a coordinate by one bit.
  function automatic diff_t ext(coord_t c);
    return {c[CoordWidth-1], c};
  endfunction

  // Differences to the segment start on each axis.
  always_comb begin
    diff_d.dx  = ext(seg_end_x_i) - ext(seg_start_x_i);
    diff_d.dy  = ext(seg_end_y_i) - ext(seg_start_y_i);
    diff_d.ox0 = ext(box_min_x_i) - ext(seg_start_x_i);
    diff_d.ox1 = ext(box_max_x_i) - ext(seg_start_x_i);
    diff_d.oy0 = ext(box_min_y_i) - ext(seg_start_y_i);
    diff_d.oy1 = ext(box_max_y_i) - ext(seg_start_y_i);
  end

  // The stage takes a request when empty or when its content moves on.
  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      diff_q <= diff_d;
    end
  end

  assign valid_o = valid_q;
  assign diff_o  = diff_q;

endmodule

FILE: rtl/sbec_norm.sv
// Second pipeline stage: sets up the four side tests, flips signs so the
// tested delta is positive and checks the parameter range. Depends on sbec_pkg.
module sbec_norm (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  sbec_pkg::diff_set_t diff_i,
  output logic                valid_o,
  input  logic                ready_i,
  output sbec_pkg::side_arr_t side_o
);
  import sbec_pkg::*;

  logic      valid_q;
  side_arr_t side_d, side_q;

  function automatic norm_t ext(diff_t v);
    return {v[DiffWidth-1], v};
  endfunction

  // Build one side test: n and d on the tested axis, span and delta on the other.
  function automatic side_t make_side(diff_t n, diff_t d, diff_t lo, diff_t hi, diff_t dv);
    side_t s;
    norm_t nn;
    norm_t dd;
    nn     = d[DiffWidth-1] ? -ext(n) : ext(n);
    dd     = d[DiffWidth-1] ? -ext(d) : ext(d);
    s.n    = nn;
    s.d    = dd;
    s.dv   = ext(dv);
    s.lo   = ext(lo);
    s.hi   = ext(hi);
    s.live = (dd != '0) && !nn[NormWidth-1] && (nn <= dd);
    return s;
  endfunction

  // Sides x = min, x = max, y = min, y = max.
  always_comb begin
    side_d[0] = make_side(diff_i.ox0, diff_i.dx, diff_i.oy0, diff_i.oy1, diff_i.dy);
    side_d[1] = make_side(diff_i.ox1, diff_i.dx, diff_i.oy0, diff_i.oy1, diff_i.dy);
    side_d[2] = make_side(diff_i.oy0, diff_i.dy, diff_i.ox0, diff_i.ox1, diff_i.dx);
    side_d[3] = make_side(diff_i.oy1, diff_i.dy, diff_i.ox0, diff_i.ox1, diff_i.dx);
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      side_q <= side_d;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;

endmodule

FILE: rtl/sbec_mul.sv
// Third pipeline stage: the cross products of the four side tests,
// three narrow signed multiplies per side. Depends on sbec_pkg.
module sbec_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  sbec_pkg::side_arr_t side_i,
  output logic                valid_o,
  input  logic                ready_i,
  output sbec_pkg::prod_arr_t prod_o
);
  import sbec_pkg::*;

  logic      valid_q;
  prod_arr_t prod_d, prod_q;

  // Products compared against each other in the last stage.
  always_comb begin
    for (int i = 0; i < NumSides; i++) begin
      prod_d[i].live  = side_i[i].live;
      prod_d[i].lo_p  = prod_t'(side_i[i].lo) * prod_t'(side_i[i].d);
      prod_d[i].mid_p = prod_t'(side_i[i].n) * prod_t'(side_i[i].dv);
      prod_d[i].hi_p  = prod_t'(side_i[i].hi) * prod_t'(side_i[i].d);
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

FILE: rtl/sbec_cmp.sv
// Last pipeline stage: span comparisons and the count of crossed sides,
// held in the output register. Depends on sbec_pkg.
module sbec_cmp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  sbec_pkg::prod_arr_t               prod_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [sbec_pkg::CountWidth-1:0]   count_o
);
  import sbec_pkg::*;

  logic                  valid_q;
  logic [NumSides-1:0]   hit;
  logic [CountWidth-1:0] count_d, count_q;

  // A side counts when its parameter is in range and the crossing lies in the span.
  always_comb begin
    count_d = '0;
    for (int i = 0; i < NumSides; i++) begin
      hit[i]  = prod_i[i].live && (prod_i[i].lo_p <= prod_i[i].mid_p)
                && (prod_i[i].mid_p <= prod_i[i].hi_p);
      count_d = count_d + CountWidth'(hit[i]);
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      count_q <= count_d;
    end
  end

  assign valid_o = valid_q;
  assign count_o = count_q;

endmodule

FILE: rtl/segment_box_edge_crossing_count.sv
// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    box_min/max_x/y_i, seg_start/end_x/y_i
// output    out_valid_o / out_ready_i  crossing_count_o
//
// Four register stages (differences, sign setup, products, compare and count);
// a request moves through them in that order and may be held in any of them.
// One request per cycle unless stalled; the multiplier stage sets the clock period.
// Each stage holds its own valid bit and takes a new request when empty or
// when its content moves on, so bubbles fill while the output is stalled.
// Reset clears the valid bits only.
module segment_box_edge_crossing_count (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  sbec_pkg::coord_t                box_min_x_i,
  input  sbec_pkg::coord_t                box_min_y_i,
  input  sbec_pkg::coord_t                box_max_x_i,
  input  sbec_pkg::coord_t                box_max_y_i,
  input  sbec_pkg::coord_t                seg_start_x_i,
  input  sbec_pkg::coord_t                seg_start_y_i,
  input  sbec_pkg::coord_t                seg_end_x_i,
  input  sbec_pkg::coord_t                seg_end_y_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sbec_pkg::CountWidth-1:0] crossing_count_o
);
  import sbec_pkg::*;

  logic      diff_valid, norm_valid, mul_valid;
  logic      norm_ready, mul_ready, cmp_ready;
  diff_set_t diff;
  side_arr_t side;
  prod_arr_t prod;

  // Stage 1: offsets from the segment start.
  sbec_diff u_diff (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (in_valid_i),
    .ready_o       (in_ready_o),
    .box_min_x_i   (box_min_x_i),
    .box_min_y_i   (box_min_y_i),
    .box_max_x_i   (box_max_x_i),
    .box_max_y_i   (box_max_y_i),
    .seg_start_x_i (seg_start_x_i),
    .seg_start_y_i (seg_start_y_i),
    .seg_end_x_i   (seg_end_x_i),
    .seg_end_y_i   (seg_end_y_i),
    .valid_o       (diff_valid),
    .ready_i       (norm_ready),
    .diff_o        (diff)
  );

  // Stage 2: side test setup.
  sbec_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (diff_valid),
    .ready_o (norm_ready),
    .diff_i  (diff),
    .valid_o (norm_valid),
    .ready_i (mul_ready),
    .side_o  (side)
  );

  // Stage 3: cross products.
  sbec_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (norm_valid),
    .ready_o (mul_ready),
    .side_i  (side),
    .valid_o (mul_valid),
    .ready_i (cmp_ready),
    .prod_o  (prod)
  );

  // Stage 4: comparisons and count.
  sbec_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mul_valid),
    .ready_o (cmp_ready),
    .prod_i  (prod),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .count_o (crossing_count_o)
  );

  // The count never exceeds the number of sides.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (crossing_count_o <= MaxCount))
    else $error("crossing count above side count");

  // Input back-pressure only when the whole pipeline is full and the output stalls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i && mul_valid && norm_valid && diff_valid))
    else $error("input stalled with room in the pipeline");

  // A new result comes only from an item held in the product stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(mul_valid))
    else $error("result appeared without a request behind it");

endmodule

FILE: tb/sv/segment_box_edge_crossing_count_tb.sv
`timescale 1ns / 100ps
// Testbench for the segment/box side crossing counter: directed and random requests.
// Each accepted request is predicted in place and checked in order; needs sbec_pkg and the RTL.
module segment_box_edge_crossing_count_tb;
  import sbec_pkg::*;

  // One request: box corners and segment endpoints.
  typedef struct packed {
    coord_t box_min_x;
    coord_t box_min_y;
    coord_t box_max_x;
    coord_t box_max_y;
    coord_t seg_start_x;
    coord_t seg_start_y;
    coord_t seg_end_x;
    coord_t seg_end_y;
  } seg_box_req_t;

  localparam int RandomRequests = 1600;
  localparam int MaxReported    = 10;
  localparam int DrainCycles    = 20;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_ready_o;
  coord_t                box_min_x_i  = '0;
  coord_t                box_min_y_i  = '0;
  coord_t                box_max_x_i  = '0;
  coord_t                box_max_y_i  = '0;
  coord_t                seg_start_x_i = '0;
  coord_t                seg_start_y_i = '0;
  coord_t                seg_end_x_i  = '0;
  coord_t                seg_end_y_i  = '0;
  logic                  out_valid_o;
  logic                  out_ready_i  = 1'b0;
  logic [CountWidth-1:0] crossing_count_o;

  seg_box_req_t          pending_requests[$];
  logic [CountWidth-1:0] expected_counts[$];
  seg_box_req_t          cur_req;
  int                    tx_wait = 0;
  int                    rx_wait = 0;
  bit                    tx_burst = 1'b0;
  bit                    rx_burst = 1'b0;
  int                    mismatch_count = 0;

  segment_box_edge_crossing_count dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .box_min_x_i      (box_min_x_i),
    .box_min_y_i      (box_min_y_i),
    .box_max_x_i      (box_max_x_i),
    .box_max_y_i      (box_max_y_i),
    .seg_start_x_i    (seg_start_x_i),
    .seg_start_y_i    (seg_start_y_i),
    .seg_end_x_i      (seg_end_x_i),
    .seg_end_y_i      (seg_end_y_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .crossing_count_o (crossing_count_o)
  );

  // Clock with a 2 ns period.
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // One side line test. The tested axis delta is made positive, then the
  // parameter range and the span on the other axis are checked by exact products.
  function automatic bit side_line_hit(longint n, longint d, longint lo, longint hi,
                                       longint dv);
    if (d == 0) return 1'b0;
    if (d < 0) begin
      d = -d;
      n = -n;
    end
    if (n < 0 || n > d) return 1'b0;
    return (lo * d <= n * dv) && (n * dv <= hi * d);
  endfunction

  // Number of box sides that the segment meets, all bounds inclusive.
  function automatic logic [CountWidth-1:0] count_side_crossings(seg_box_req_t r);
    longint sx, sy, dx, dy, ox0, ox1, oy0, oy1;
    int unsigned hits;
    sx  = r.seg_start_x;
    sy  = r.seg_start_y;
    dx  = longint'(r.seg_end_x) - sx;
    dy  = longint'(r.seg_end_y) - sy;
    ox0 = longint'(r.box_min_x) - sx;
    ox1 = longint'(r.box_max_x) - sx;
    oy0 = longint'(r.box_min_y) - sy;
    oy1 = longint'(r.box_max_y) - sy;
    hits = side_line_hit(ox0, dx, oy0, oy1, dy) + side_line_hit(ox1, dx, oy0, oy1, dy)
         + side_line_hit(oy0, dy, ox0, ox1, dx) + side_line_hit(oy1, dy, ox0, ox1, dx);
    return hits[CountWidth-1:0];
  endfunction

  function automatic coord_t clamp_coord(longint v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  // A small signed coordinate in -20 to 20.
  function automatic longint small_coord();
    return longint'($urandom_range(0, 40)) - 20;
  endfunction

  task automatic add_request(longint bx0, longint by0, longint bx1, longint by1,
                             longint sx, longint sy, longint ex, longint ey);
    seg_box_req_t r;
    r.box_min_x   = clamp_coord(bx0);
    r.box_min_y   = clamp_coord(by0);
    r.box_max_x   = clamp_coord(bx1);
    r.box_max_y   = clamp_coord(by1);
    r.seg_start_x = clamp_coord(sx);
    r.seg_start_y = clamp_coord(sy);
    r.seg_end_x   = clamp_coord(ex);
    r.seg_end_y   = clamp_coord(ey);
    pending_requests.push_back(r);
  endtask

  // A box of random size around a random center and a segment near it.
  // Endpoints are sometimes snapped onto box corners or sides to hit the bounds.
  task automatic add_local_request(int spread);
    longint cx, cy, hx, hy, p[4];
    cx = $signed(coord_t'($urandom));
    cy = $signed(coord_t'($urandom));
    hx = $urandom_range(0, spread);
    hy = $urandom_range(0, spread);
    for (int k = 0; k < 4; k++) begin
      p[k] = ((k % 2 == 0) ? cx : cy) + $urandom_range(0, 6 * spread) - 3 * spread;
    end
    case ($urandom_range(0, 5))
      0: begin
        p[0] = cx - hx;
        p[1] = cy - hy;
      end
      1: begin
        p[2] = cx + hx;
        p[3] = cy + hy;
      end
      2: p[0] = cx + hx;
      3: p[3] = cy - hy;
      4: p[2] = p[0];
      default: ;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      add_request(cx + hx, cy - hy, cx - hx, cy + hy, p[0], p[1], p[2], p[3]);
    end else begin
      add_request(cx - hx, cy - hy, cx + hx, cy + hy, p[0], p[1], p[2], p[3]);
    end
  endtask

  // Request driver: presents queued requests with a random wait between them.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_counts.push_back(count_side_crossings(cur_req));
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_wait > 0) begin
          tx_wait = tx_wait - 1;
          in_valid_i <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          cur_req = pending_requests.pop_front();
          box_min_x_i   <= cur_req.box_min_x;
          box_min_y_i   <= cur_req.box_min_y;
          box_max_x_i   <= cur_req.box_max_x;
          box_max_y_i   <= cur_req.box_max_y;
          seg_start_x_i <= cur_req.seg_start_x;
          seg_start_y_i <= cur_req.seg_start_y;
          seg_end_x_i   <= cur_req.seg_end_x;
          seg_end_y_i   <= cur_req.seg_end_y;
          in_valid_i    <= 1'b1;
          if ($urandom_range(0, 31) == 0) tx_burst = !tx_burst;
          tx_wait = tx_burst ? 0 : $urandom_range(0, 7);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted count and stalls at random after it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_counts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxReported) begin
            $display("unexpected result: count %0d with no request in flight",
                     crossing_count_o);
          end
        end else begin
          logic [CountWidth-1:0] want;
          want = expected_counts.pop_front();
          if (crossing_count_o !== want) begin
            mismatch_count++;
            if (mismatch_count <= MaxReported) begin
              $display("crossing_count mismatch: expected %0d, actual %0d", want,
                       crossing_count_o);
            end
          end
        end
        if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(0, 7);
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
      end
      out_ready_i <= (rx_wait == 0);
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    // Directed requests: nominal crossings, corners, zero deltas, odd boxes, extremes.
    add_request(0, 0, 0, 0, 0, 0, 0, 0);
    add_request(-10, -10, 10, 10, -20, 0, 20, 0);
    add_request(-10, -10, 10, 10, 0, 20, 0, -20);
    add_request(-10, -10, 10, 10, -20, -20, 20, 20);
    add_request(-10, -10, 10, 10, 20, -20, -20, 20);
    add_request(-10, -10, 10, 10, -20, 0, 0, 20);
    add_request(-10, -10, 10, 10, -5, -5, 5, 5);
    add_request(-10, -10, 10, 10, -10, 0, 5, 3);
    add_request(-10, -10, 10, 10, 3, 0, 3, 7);
    add_request(-10, -10, 10, 10, 30, -20, 40, 20);
    add_request(-10, -10, 10, 10, -10, -10, -10, -10);
    add_request(10, -10, -10, 10, -20, 0, 20, 0);
    add_request(-10, 10, 10, -10, 0, -20, 0, 20);
    add_request(0, -10, 0, 10, -5, 0, 5, 0);
    add_request(-10, 4, 10, 4, 0, -5, 0, 5);
    add_request(0, 0, 0, 0, -3, -3, 3, 3);
    add_request(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767);
    add_request(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767);
    add_request(-32768, -32768, 32767, 32767, -32768, 0, 32767, 0);
    add_request(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    add_request(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    add_request(32767, 32767, -32768, -32768, -32768, 32767, 32767, -32768);
    add_request(-32768, -32768, 32767, 32767, 0, 0, 1, 1);
    add_request(-1, -1, 1, 1, 32767, 32767, -32768, -32768);

    // Random requests: mostly local geometry, some small or full-range noise.
    for (int i = 0; i < RandomRequests; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          add_request(small_coord(), small_coord(), small_coord(), small_coord(),
                      small_coord(), small_coord(), small_coord(), small_coord());
        end
        2: begin
          add_request($signed(coord_t'($urandom)), $signed(coord_t'($urandom)),
                      $signed(coord_t'($urandom)), $signed(coord_t'($urandom)),
                      $signed(coord_t'($urandom)), $signed(coord_t'($urandom)),
                      $signed(coord_t'($urandom)), $signed(coord_t'($urandom)));
        end
        3: add_local_request(12000);
        default: add_local_request(($urandom_range(0, 1) == 0) ? 8 : 200);
      endcase
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait until every request is taken and every result has come back.
    while (pending_requests.size() > 0 || in_valid_i) @(negedge clk_i);
    while (expected_counts.size() > 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (mismatch_count == 0 && expected_counts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard limit on the run time.
  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
